/* rtl/bid_pkg.sv */
// ----------------------------------------------------------------------------
// bid_pkg
// shared constants, command and status codes and the control/status structs
// passed between the deque controller and its datapath
// ----------------------------------------------------------------------------
package bid_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_FILL       = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_EMPTY = 2'd3
  } stat_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch the incoming item
    logic exec;       // carry out the latched command
    logic capture;    // take read data into the result
    logic fill_step;  // write one fill entry
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic pop_go;     // pop will read an entry
    logic fill_go;    // fill accepted with at least one entry
    logic fill_last;  // current fill write is the last one
  } dp_stat_t;

endpackage

/* rtl/bounded_int_deque_core.sv */
// ----------------------------------------------------------------------------
// bounded_int_deque_core
// bounded double-ended queue of signed 32-bit values in a 64-entry ring store
// ----------------------------------------------------------------------------
// a command is taken when start is high and busy is low; busy stays high
// until its single result is out. the result sits on popped_value, status and
// entry_count for exactly one cycle, marked by done, and must be taken then:
// there is no way to hold it off. pushes, clear and refused or empty commands
// go from execute straight to done, successful pops pass a read wait state
// first (the ring store read is registered), and a fill writes its entries in
// a sweep state, since the single write port of the store is swept one entry
// a cycle. a new command may be given in the same cycle that done is high.
// ----------------------------------------------------------------------------
module bounded_int_deque_core import bid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // command side
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic [CNT_W-1:0]         fill_count,
  // result side
  output logic                     done,
  output logic signed [DATA_W-1:0] popped_value,
  output logic [STAT_W-1:0]        status,
  output logic [CNT_W-1:0]         entry_count
);

  // command and status between controller and datapath
  dp_ctl_t  dp_ctl;
  dp_stat_t dp_stat;

  // sequencer: idle, execute, read wait, fill sweep
  bid_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .dp_stat (dp_stat),
    .dp_ctl  (dp_ctl),
    .busy    (busy),
    .done    (done)
  );

  // ring store with head index and count, plus the result registers that
  // hold the item shown while done is high
  bid_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .dp_ctl       (dp_ctl),
    .cmd          (cmd),
    .push_value   (push_value),
    .fill_count   (fill_count),
    .dp_stat      (dp_stat),
    .popped_value (popped_value),
    .status       (status),
    .entry_count  (entry_count)
  );

endmodule

/* rtl/bid_ctrl.sv */
// ----------------------------------------------------------------------------
// bid_ctrl
// sequencing state machine: accept, execute, read wait and fill loop
// ----------------------------------------------------------------------------
module bid_ctrl import bid_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t dp_stat,
  output dp_ctl_t  dp_ctl,
  output logic     busy,
  output logic     done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_FILL
  } state_t;

  state_t state;

  always_comb begin
    dp_ctl.load      = (state == S_IDLE) && start;
    dp_ctl.exec      = (state == S_EXEC);
    dp_ctl.capture   = (state == S_READ);
    dp_ctl.fill_step = (state == S_FILL);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (dp_stat.pop_go) begin
            state <= S_READ;
          end else if (dp_stat.fill_go) begin
            state <= S_FILL;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_READ: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        S_FILL: begin
          if (dp_stat.fill_last) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/bid_dpath.sv */
// ----------------------------------------------------------------------------
// bid_dpath
// ring store, head index, entry count, fill counter and result registers
// ----------------------------------------------------------------------------
module bid_dpath import bid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_ctl_t                  dp_ctl,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic [CNT_W-1:0]         fill_count,
  output dp_stat_t                 dp_stat,
  output logic signed [DATA_W-1:0] popped_value,
  output logic [STAT_W-1:0]        status,
  output logic [CNT_W-1:0]         entry_count
);

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] push_q;
  logic [CNT_W-1:0]  fill_q;

  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  fill_k, fill_k_next;
  logic [CNT_W-1:0]  fill_n, fill_n_next;
  logic [DATA_W-1:0] rd_data;

  logic [DATA_W-1:0] res_value, res_value_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic [CNT_W-1:0]  res_count, res_count_next;

  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data;

  logic              is_empty, is_full, is_pop;
  logic [CNT_W-1:0]  fill_sat;

  assign is_empty = (count == '0);
  assign is_full  = (count >= CNT_W'(CAPACITY));
  assign is_pop   = (cmd_q == OP_POP_FRONT) || (cmd_q == OP_POP_BACK);
  assign fill_sat = (fill_q > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : fill_q;

  always_comb begin
    dp_stat.pop_go    = is_pop && !is_empty;
    dp_stat.fill_go   = (cmd_q == OP_FILL) && is_empty && (fill_sat != '0);
    dp_stat.fill_last = ({1'b0, fill_k} == (fill_n - CNT_W'(1)));
  end

  always_comb begin
    head_next       = head;
    count_next      = count;
    fill_k_next     = fill_k;
    fill_n_next     = fill_n;
    res_value_next  = res_value;
    res_status_next = res_status;
    res_count_next  = res_count;
    wr_en           = 1'b0;
    wr_addr         = head;
    wr_data         = push_q;
    rd_en           = 1'b0;
    rd_addr         = head;

    if (dp_ctl.exec) begin
      res_value_next  = '0;
      res_status_next = ST_OK;
      case (cmd_q)
        OP_PUSH_FRONT: begin
          if (is_full) begin
            res_status_next = ST_FULL;
          end else begin
            head_next  = head - IDX_W'(1);
            wr_en      = 1'b1;
            wr_addr    = head - IDX_W'(1);
            count_next = count + CNT_W'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (is_full) begin
            res_status_next = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = head + count[IDX_W-1:0];
            count_next = count + CNT_W'(1);
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            res_status_next = ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = head;
            head_next  = head + IDX_W'(1);
            count_next = count - CNT_W'(1);
          end
        end
        OP_POP_BACK: begin
          if (is_empty) begin
            res_status_next = ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = head + count[IDX_W-1:0] - IDX_W'(1);
            count_next = count - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          head_next  = '0;
          count_next = '0;
        end
        OP_FILL: begin
          if (!is_empty) begin
            res_status_next = ST_NOT_EMPTY;
          end else begin
            head_next   = '0;
            fill_k_next = '0;
            fill_n_next = fill_sat;
          end
        end
        default: begin
        end
      endcase
      res_count_next = count_next;
    end

    if (dp_ctl.capture) begin
      res_value_next = rd_data;
    end

    if (dp_ctl.fill_step) begin
      wr_en       = 1'b1;
      wr_addr     = fill_k;
      wr_data     = DATA_W'(fill_k) + DATA_W'(1);
      fill_k_next = fill_k + IDX_W'(1);
      if (dp_stat.fill_last) begin
        count_next     = fill_n;
        res_count_next = fill_n;
      end
    end
  end

  // ring store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_ctl.load) begin
      cmd_q  <= cmd;
      push_q <= push_value;
      fill_q <= fill_count;
    end
    fill_k     <= fill_k_next;
    fill_n     <= fill_n_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    res_count  <= res_count_next;
  end

  assign popped_value = res_value;
  assign status       = res_status;
  assign entry_count  = res_count;

endmodule

/* tb/tb_bounded_int_deque_core.sv */
// ----------------------------------------------------------------------------
// tb_bounded_int_deque_core
// self-checking bench for the bounded double-ended queue core: a short table
// of directed commands, then about 1850 random commands in three idling
// phases, each result compared field by field with a cycle-free shadow queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bounded_int_deque_core;
  import bid_pkg::*;

  // command codes the block treats as no operation
  localparam logic [CMD_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 617;           // per idling phase
  localparam int DRAIN_CYCLES  = CAPACITY + 16; // longer than the slowest fill
  localparam int DIRECTED_ROWS = 25;

  typedef struct {
    logic signed [DATA_W-1:0] popped;
    stat_t                    st;
    logic [CNT_W-1:0]         count;
  } deque_res_t;

  // one command item, with an expected result typed in where fixed is set
  typedef struct {
    logic [CMD_W-1:0]         op;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         n;
    bit                       fixed;
    deque_res_t               want;
  } deque_cmd_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         cmd = OP_CLEAR;
  logic signed [DATA_W-1:0] push_value = '0;
  logic [CNT_W-1:0]         fill_count = '0;
  logic                     done;
  logic signed [DATA_W-1:0] popped_value;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         entry_count;

  // shadow copy of the queue, advanced once per accepted item
  logic signed [DATA_W-1:0] shadow_store [CAPACITY];
  logic [IDX_W-1:0]         shadow_head = '0;
  logic [CNT_W-1:0]         shadow_level = '0;

  deque_res_t pending_results [$];
  int         mismatch_count = 0;
  int         sender_idle_pct = 28;
  int         push_weight = 55;
  int         cycle_count = 0;

  bounded_int_deque_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .push_value   (push_value),
    .fill_count   (fill_count),
    .done         (done),
    .popped_value (popped_value),
    .status       (status),
    .entry_count  (entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // directed table: rows with fixed set carry their result typed in, the
  // rest are left to the shadow queue
  deque_cmd_t directed_rows [DIRECTED_ROWS] = '{
    // empty queue after reset: both pops report empty
    '{OP_POP_FRONT,  32'sd0,           7'd0,   1'b1, '{32'sd0,  ST_EMPTY,     7'd0}},
    '{OP_POP_BACK,   32'sd0,           7'd0,   1'b1, '{32'sd0,  ST_EMPTY,     7'd0}},
    // fill of zero leaves the queue empty
    '{OP_FILL,       32'sd0,           7'd0,   1'b1, '{32'sd0,  ST_OK,        7'd0}},
    // fill above capacity saturates to a full queue of 1..64
    '{OP_FILL,       32'sd0,           7'd127, 1'b1, '{32'sd0,  ST_OK,        7'd64}},
    // pushes on a full queue are refused
    '{OP_PUSH_FRONT, 32'sd5,           7'd0,   1'b1, '{32'sd0,  ST_FULL,      7'd64}},
    '{OP_PUSH_BACK,  -32'sd7,          7'd0,   1'b1, '{32'sd0,  ST_FULL,      7'd64}},
    // fill on a non-empty queue is refused
    '{OP_FILL,       32'sd0,           7'd3,   1'b1, '{32'sd0,  ST_NOT_EMPTY, 7'd64}},
    '{OP_POP_FRONT,  32'sd0,           7'd0,   1'b1, '{32'sd1,  ST_OK,        7'd63}},
    '{OP_POP_BACK,   32'sd0,           7'd0,   1'b1, '{32'sd64, ST_OK,        7'd62}},
    // spare command codes change nothing
    '{OP_SPARE_6,    32'sd9,           7'd9,   1'b1, '{32'sd0,  ST_OK,        7'd62}},
    '{OP_SPARE_7,    -32'sd1,          7'd127, 1'b1, '{32'sd0,  ST_OK,        7'd62}},
    '{OP_CLEAR,      32'sd0,           7'd0,   1'b1, '{32'sd0,  ST_OK,        7'd0}},
    // value extremes, with the head wrapping below slot zero
    '{OP_PUSH_FRONT, 32'sh8000_0000,   7'd0,   1'b0, '{32'sd0,  ST_OK,        7'd0}},
    '{OP_PUSH_BACK,  32'sh7fff_ffff,   7'd0,   1'b0, '{32'sd0,  ST_OK,        7'd0}},
    '{OP_PUSH_FRONT, -32'sd1,          7'd0,   1'b0, '{32'sd0,  ST_OK,        7'd0}},
    '{OP_POP_BACK,   32'sd0,           7'd0,   1'b0, '{32'sd0,  ST_OK,        7'd0}},
    '{OP_POP_FRONT,  32'sd0,           7'd0,   1'b0, '{32'sd0,  ST_OK,        7'd0}},
    '{OP_POP_FRONT,  32'sd0,           7'd0,   1'b0, '{32'sd0,  ST_OK,        7'd0}},
    '{OP_POP_FRONT,  32'sd0,           7'd0,   1'b1, '{32'sd0,  ST_EMPTY,     7'd0}},
    '{OP_FILL,       32'sd0,           7'd1,   1'b1, '{32'sd0,  ST_OK,        7'd1}},
    '{OP_PUSH_FRONT, 32'sd0,           7'd0,   1'b0, '{32'sd0,  ST_OK,        7'd0}},
    '{OP_POP_BACK,   32'sd0,           7'd0,   1'b0, '{32'sd0,  ST_OK,        7'd0}},
    '{OP_CLEAR,      32'sd0,           7'd0,   1'b1, '{32'sd0,  ST_OK,        7'd0}},
    '{OP_FILL,       32'sd0,           7'd64,  1'b1, '{32'sd0,  ST_OK,        7'd64}},
    '{OP_CLEAR,      32'sd0,           7'd0,   1'b1, '{32'sd0,  ST_OK,        7'd0}}
  };

  // apply one command to the shadow queue and return the result it causes
  function automatic deque_res_t deque_apply(input logic [CMD_W-1:0] op,
                                             input logic signed [DATA_W-1:0] value,
                                             input logic [CNT_W-1:0] n);
    deque_res_t       res;
    logic [IDX_W-1:0] slot;
    int               fill_n;
    res = '{popped: '0, st: ST_OK, count: '0};
    case (op)
      OP_PUSH_FRONT: begin
        if (shadow_level >= CNT_W'(CAPACITY)) begin
          res.st = ST_FULL;
        end else begin
          shadow_head               = shadow_head - IDX_W'(1);
          shadow_store[shadow_head] = value;
          shadow_level              = shadow_level + CNT_W'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_level >= CNT_W'(CAPACITY)) begin
          res.st = ST_FULL;
        end else begin
          slot               = shadow_head + shadow_level[IDX_W-1:0];
          shadow_store[slot] = value;
          shadow_level       = shadow_level + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (shadow_level == '0) begin
          res.st = ST_EMPTY;
        end else begin
          res.popped   = shadow_store[shadow_head];
          shadow_head  = shadow_head + IDX_W'(1);
          shadow_level = shadow_level - CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (shadow_level == '0) begin
          res.st = ST_EMPTY;
        end else begin
          // a full ring wraps the index to the slot just behind the head
          slot         = shadow_head + shadow_level[IDX_W-1:0] - IDX_W'(1);
          res.popped   = shadow_store[slot];
          shadow_level = shadow_level - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        shadow_head  = '0;
        shadow_level = '0;
      end
      OP_FILL: begin
        if (shadow_level != '0) begin
          res.st = ST_NOT_EMPTY;
        end else begin
          fill_n      = (int'(n) > CAPACITY) ? CAPACITY : int'(n);
          shadow_head = '0;
          for (int k = 0; k < fill_n; k++) shadow_store[IDX_W'(k)] = k + 1;
          shadow_level = CNT_W'(fill_n);
        end
      end
      default: ;
    endcase
    res.count = shadow_level;
    return res;
  endfunction

  // present one item, wait until busy drops, then log its expected result;
  // start is only lowered when a gap is inserted, so it never toggles twice
  // in one step
  task automatic issue_item(input deque_cmd_t item);
    deque_res_t predicted;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start      <= 1'b1;
    cmd        <= item.op;
    push_value <= item.value;
    fill_count <= item.n;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predicted = deque_apply(item.op, item.value, item.n);
    if (item.fixed) pending_results.push_back(item.want);
    else pending_results.push_back(predicted);
  endtask

  // random command, biased by push_weight so the queue swings between
  // empty and full and the head wraps round the ring in both directions
  task automatic random_item();
    deque_cmd_t item;
    int         pick;
    item.fixed = 1'b0;
    item.want  = '{popped: '0, st: ST_OK, count: '0};
    case ($urandom_range(9))
      0:       item.value = 32'sh8000_0000;
      1:       item.value = 32'sh7fff_ffff;
      2:       item.value = $urandom_range(255) - 128;
      default: item.value = $urandom;
    endcase
    // mostly short fills, a few at or past capacity, now and then zero
    case ($urandom_range(19))
      0:       item.n = '0;
      1:       item.n = CNT_W'($urandom_range(127, 65));
      2, 3, 4: item.n = CNT_W'($urandom_range(64, 9));
      default: item.n = CNT_W'($urandom_range(8, 1));
    endcase
    pick = $urandom_range(99);
    if (shadow_level == '0 && pick < 30) item.op = OP_FILL;
    else if (pick < push_weight) item.op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    else if (pick < 91) item.op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    else if (pick < 94) item.op = OP_FILL;
    else if (pick < 97) item.op = OP_CLEAR;
    else item.op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
    issue_item(item);
  endtask

  // result checker: done marks a result for exactly one cycle
  always @(posedge clk) begin
    deque_res_t want;
    if (rst === 1'b0 && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display({"%0t: unexpected result, expected none, actual popped_value %0d",
                  " status %0d entry_count %0d"},
                 $time, popped_value, status, entry_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (popped_value !== want.popped) begin
          $display("%0t: popped_value mismatch, expected %0d actual %0d",
                   $time, want.popped, popped_value);
          mismatch_count++;
        end
        if (status !== want.st) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time, want.st, status);
          mismatch_count++;
        end
        if (entry_count !== want.count) begin
          $display("%0t: entry_count mismatch, expected %0d actual %0d",
                   $time, want.count, entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: cycle counter well above the slowest legal run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int phase_idle [3];
    phase_idle = '{28, 74, 0};

    // hold the synchronous reset, then release it
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, under the first idling setting
    sender_idle_pct = phase_idle[0];
    foreach (directed_rows[i]) issue_item(directed_rows[i]);

    // random phases: sender idles sometimes, then often, then never
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = phase_idle[ph];
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        if (i % 40 == 0) begin
          case ($urandom_range(2))
            0:       push_weight = 35;
            1:       push_weight = 55;
            default: push_weight = 80;
          endcase
        end
        random_item();
      end
    end
    start <= 1'b0;

    // drain outstanding results, then watch a while for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* bounded_int_deque_core.f */
rtl/bid_pkg.sv
rtl/bid_ctrl.sv
rtl/bid_dpath.sv
rtl/bounded_int_deque_core.sv
tb/tb_bounded_int_deque_core.sv
